>>> hw/rtl/lhp_pkg.sv
// Shared types and constants of the linear probe hash map unit.
package lhp_pkg;

  localparam int KEY_W  = 31;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 9;
  localparam int MARK_W = 2;
  localparam int STAT_W = 2;

  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  localparam logic REG_ACTIVE_SIZE = 1'b0;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_LOOK,
    S_CHK,
    S_ACT
  } state_t;

  typedef struct packed {
    logic mark_we;
    logic kv_we;
  } wr_en_t;

endpackage

>>> hw/rtl/linear_probe_hash_map_unit.sv
// Top level: open-addressing hash map with linear probing.
//
// Requests arrive on the in_ stream (command, key, value); each request
// yields exactly one response on the out_ stream (status, read_value).
// active_size (APB register 0) sets the number of slots in use; the user
// must write it only while the unit is idle, the block does not enforce it.
// Sequence: after a request is taken, the home slot (key modulo size)
// comes from an iterative remainder unit, then the S_LOOK state starts
// the slot memory read, the probe checks one slot per cycle, and the
// S_ACT state updates the memory and loads the response register once
// the output register is free. The next request is taken the cycle after
// the update. Command 3 skips the remainder unit and the probe.
// Reset: a clearing pass marks every slot empty, with in_tready low;
// APB writes are taken during it.
// Stall: the response waits in the output register while out_tready is
// low; the next request is still taken and processed up to its update.
module linear_probe_hash_map_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // command[1:0], key[32:2], value[64:33]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[1:0], read_value[33:2]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int LW    = (IDX_W + 1 > lhp_pkg::CFG_W) ? IDX_W + 1 : lhp_pkg::CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  lhp_pkg::state_t state_r, state_nxt;

  logic [lhp_pkg::CFG_W-1:0]  active_size_r;
  logic [lhp_pkg::CFG_W-1:0]  live_n;
  logic [IDX_W-1:0]           clr_addr_r, clr_addr_nxt;

  lhp_pkg::cmd_t              cmd_r, cmd_nxt;
  logic [lhp_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [lhp_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]           addr_r, addr_nxt, addr_wrap;
  logic [IDX_W-1:0]           cnt_r, cnt_nxt;
  logic                       tomb_v_r, tomb_v_nxt;
  logic [IDX_W-1:0]           tomb_r, tomb_nxt;
  logic                       found_r, found_nxt;
  logic                       slot_v_r, slot_v_nxt;
  logic [IDX_W-1:0]           slot_r, slot_nxt;
  logic [lhp_pkg::DATA_W-1:0] rd_r, rd_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [lhp_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [lhp_pkg::DATA_W-1:0] out_rd_r, out_rd_nxt;

  logic                       in_acc, out_free, cfg_wr;
  logic                       mod_start, mod_done;
  logic [lhp_pkg::CFG_W-1:0]  mod_rem;

  logic [IDX_W-1:0]           mem_raddr, mem_waddr;
  lhp_pkg::wr_en_t            mem_we;
  logic [lhp_pkg::MARK_W-1:0] mem_wmark, mem_rmark;
  logic [lhp_pkg::KEY_W-1:0]  mem_rkey;
  logic [lhp_pkg::DATA_W-1:0] mem_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= lhp_pkg::SIZE_RESET;
    end else if (cfg_wr && cfg_paddr[2] == lhp_pkg::REG_ACTIVE_SIZE) begin
      active_size_r <= cfg_pwdata[lhp_pkg::CFG_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == lhp_pkg::REG_ACTIVE_SIZE)
                    ? {{(32-lhp_pkg::CFG_W){1'b0}}, active_size_r} : 32'd0;

  always_comb begin
    if (active_size_r == '0) begin
      live_n = lhp_pkg::CFG_W'(1);
    end else if (int'(active_size_r) > TABLE_DEPTH) begin
      live_n = lhp_pkg::CFG_W'(TABLE_DEPTH);
    end else begin
      live_n = active_size_r;
    end
  end

  assign in_tready = (state_r == lhp_pkg::S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign mod_start = in_acc && (lhp_pkg::cmd_t'(in_tdata[1:0]) != lhp_pkg::CMD_NONE);

  assign addr_wrap = ((LW'(addr_r) + LW'(1)) == LW'(live_n)) ? '0 : addr_r + IDX_W'(1);

  lhp_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_tdata[32:2]),
    .divisor  (live_n),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  lhp_store #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .raddr (mem_raddr),
    .waddr (mem_waddr),
    .wr_en (mem_we),
    .wmark (mem_wmark),
    .wkey  (key_r),
    .wdata (val_r),
    .rmark (mem_rmark),
    .rkey  (mem_rkey),
    .rdata (mem_rdata)
  );

  always_comb begin
    logic is_used, is_empty, is_last;
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;
    tomb_v_nxt     = tomb_v_r;
    tomb_nxt       = tomb_r;
    found_nxt      = found_r;
    slot_v_nxt     = slot_v_r;
    slot_nxt       = slot_r;
    rd_nxt         = rd_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    mem_raddr      = addr_r;
    mem_waddr      = slot_r;
    mem_we         = '{mark_we: 1'b0, kv_we: 1'b0};
    mem_wmark      = lhp_pkg::MARK_USED;
    is_used        = (mem_rmark == lhp_pkg::MARK_USED);
    is_empty       = (mem_rmark == lhp_pkg::MARK_EMPTY);
    is_last        = (LW'(cnt_r) == LW'(live_n) - LW'(1));

    unique case (state_r)
      lhp_pkg::S_CLEAR: begin
        mem_waddr      = clr_addr_r;
        mem_we.mark_we = 1'b1;
        mem_wmark      = lhp_pkg::MARK_EMPTY;
        clr_addr_nxt   = clr_addr_r + IDX_W'(1);
        if (clr_addr_r == LAST_IDX) begin
          state_nxt = lhp_pkg::S_IDLE;
        end
      end
      lhp_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = lhp_pkg::cmd_t'(in_tdata[1:0]);
          key_nxt    = in_tdata[32:2];
          val_nxt    = in_tdata[64:33];
          found_nxt  = 1'b0;
          slot_v_nxt = 1'b0;
          state_nxt  = mod_start ? lhp_pkg::S_MOD : lhp_pkg::S_ACT;
        end
      end
      lhp_pkg::S_MOD: begin
        if (mod_done) begin
          addr_nxt   = IDX_W'(mod_rem);
          cnt_nxt    = '0;
          tomb_v_nxt = 1'b0;
          state_nxt  = lhp_pkg::S_LOOK;
        end
      end
      lhp_pkg::S_LOOK: begin
        state_nxt = lhp_pkg::S_CHK;
      end
      lhp_pkg::S_CHK: begin
        mem_raddr = addr_wrap;
        if (is_used && mem_rkey == key_r) begin
          found_nxt  = 1'b1;
          slot_v_nxt = 1'b1;
          slot_nxt   = addr_r;
          rd_nxt     = mem_rdata;
          state_nxt  = lhp_pkg::S_ACT;
        end else if (is_empty) begin
          slot_v_nxt = 1'b1;
          slot_nxt   = tomb_v_r ? tomb_r : addr_r;
          state_nxt  = lhp_pkg::S_ACT;
        end else begin
          if (!is_used && !tomb_v_r) begin
            tomb_v_nxt = 1'b1;
            tomb_nxt   = addr_r;
          end
          if (is_last) begin
            slot_v_nxt = tomb_v_r || !is_used;
            slot_nxt   = tomb_v_r ? tomb_r : addr_r;
            state_nxt  = lhp_pkg::S_ACT;
          end else begin
            addr_nxt = addr_wrap;
            cnt_nxt  = cnt_r + IDX_W'(1);
          end
        end
      end
      lhp_pkg::S_ACT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = lhp_pkg::ST_OK;
          out_rd_nxt     = '0;
          state_nxt      = lhp_pkg::S_IDLE;
          unique case (cmd_r)
            lhp_pkg::CMD_INSERT: begin
              if (slot_v_r) begin
                mem_we = '{mark_we: 1'b1, kv_we: 1'b1};
              end else begin
                out_status_nxt = lhp_pkg::ST_FULL;
              end
            end
            lhp_pkg::CMD_REMOVE: begin
              if (found_r) begin
                mem_we.mark_we = 1'b1;
                mem_wmark      = lhp_pkg::MARK_TOMB;
              end else begin
                out_status_nxt = lhp_pkg::ST_NOT_FOUND;
              end
            end
            lhp_pkg::CMD_SEARCH: begin
              if (found_r) begin
                out_rd_nxt = rd_r;
              end else begin
                out_status_nxt = lhp_pkg::ST_NOT_FOUND;
              end
            end
            lhp_pkg::CMD_NONE: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = lhp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lhp_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    addr_r       <= addr_nxt;
    cnt_r        <= cnt_nxt;
    tomb_v_r     <= tomb_v_nxt;
    tomb_r       <= tomb_nxt;
    found_r      <= found_nxt;
    slot_v_r     <= slot_v_nxt;
    slot_r       <= slot_nxt;
    rd_r         <= rd_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_rd_r, out_status_r};

endmodule

>>> hw/rtl/lhp_mod.sv
// Iterative remainder unit: key modulo table size, four bits per cycle.
module lhp_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lhp_pkg::KEY_W-1:0]  dividend,
  input  logic [lhp_pkg::CFG_W-1:0]  divisor,
  output logic                       done,
  output logic [lhp_pkg::CFG_W-1:0]  rem
);

  localparam int NW = lhp_pkg::CFG_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [NW-1:0] r_r, r_nxt;

  always_comb begin
    logic [NW:0]   t;
    logic [NW-1:0] r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    r        = r_r;
    t        = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = {1'b0, dividend};
      r_nxt    = '0;
    end else if (busy_r) begin
      for (int i = 0; i < 4; i++) begin
        t = {r, q_r[31-i]};
        if (t >= {1'b0, divisor}) begin
          t = t - {1'b0, divisor};
        end
        r = t[NW-1:0];
      end
      r_nxt   = r;
      q_nxt   = {q_r[27:0], 4'd0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

>>> hw/rtl/lhp_store.sv
// Slot storage: mark memory and key/data memory, registered reads.
module lhp_store #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
  input  logic [$clog2(TABLE_DEPTH)-1:0] waddr,
  input  lhp_pkg::wr_en_t             wr_en,
  input  logic [lhp_pkg::MARK_W-1:0]  wmark,
  input  logic [lhp_pkg::KEY_W-1:0]   wkey,
  input  logic [lhp_pkg::DATA_W-1:0]  wdata,
  output logic [lhp_pkg::MARK_W-1:0]  rmark,
  output logic [lhp_pkg::KEY_W-1:0]   rkey,
  output logic [lhp_pkg::DATA_W-1:0]  rdata
);

  localparam int KV_W = lhp_pkg::KEY_W + lhp_pkg::DATA_W;

  logic [lhp_pkg::MARK_W-1:0] mark_mem [TABLE_DEPTH];
  logic [KV_W-1:0]            kv_mem   [TABLE_DEPTH];
  logic [KV_W-1:0]            kv_q;

  always_ff @(posedge clk) begin
    if (wr_en.mark_we) begin
      mark_mem[waddr] <= wmark;
    end
    rmark <= mark_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_en.kv_we) begin
      kv_mem[waddr] <= {wkey, wdata};
    end
    kv_q <= kv_mem[raddr];
  end

  assign rkey  = kv_q[KV_W-1:lhp_pkg::DATA_W];
  assign rdata = kv_q[lhp_pkg::DATA_W-1:0];

endmodule

>>> verif/testbench.sv
// Testbench for the linear probe hash map unit: random streams checked against a table model.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = 256;
  localparam int QUIET_LIMIT = 4000;
  localparam int NUM_PHASES = 14;

  typedef struct packed {
    lhp_pkg::cmd_t                     cmd;
    logic [lhp_pkg::KEY_W-1:0]  key;
    logic [lhp_pkg::DATA_W-1:0] value;
  } map_req_t;

  typedef struct packed {
    logic [lhp_pkg::STAT_W-1:0] status;
    logic [lhp_pkg::DATA_W-1:0] read_value;
  } map_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;    // command[1:0], key[32:2], value[64:33]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // status[1:0], read_value[33:2]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  linear_probe_hash_map_unit #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial forever #1 clk = ~clk;

  // table model
  logic [lhp_pkg::KEY_W-1:0]  tbl_key  [DEPTH];
  logic [lhp_pkg::DATA_W-1:0] tbl_data [DEPTH];
  logic [lhp_pkg::MARK_W-1:0] tbl_mark [DEPTH];
  logic [lhp_pkg::CFG_W-1:0]  tbl_size = lhp_pkg::SIZE_RESET;

  map_req_t  request_q [$];
  map_resp_t response_q [$];
  map_req_t  in_flight;
  int        sent_count = 0;
  int        resp_count = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  bit        gaps_on = 1'b1;
  bit        failed = 1'b0;
  int        quiet = 0;

  int phase_size [NUM_PHASES] = '{3, 16, 2, 256, 0, 7, 511, 64, 257, 5, 33, 100, 12, 256};
  int phase_len  [NUM_PHASES] = '{80, 120, 60, 80, 40, 90, 60, 120, 300, 70, 100, 60, 60, 40};

  function automatic map_resp_t lookup_and_update(map_req_t r);
    map_resp_t res;
    int n, h, tomb, hit, free_slot, i;
    bit done;
    res = '{status: lhp_pkg::ST_OK, read_value: '0};
    if (r.cmd == lhp_pkg::CMD_NONE) return res;
    n = (tbl_size == 0) ? 1 : (tbl_size > DEPTH) ? DEPTH : int'(tbl_size);
    h = int'({1'b0, r.key} % n);
    tomb = -1;
    hit = -1;
    free_slot = -1;
    done = 1'b0;
    for (i = 0; i < n && !done; i++) begin
      if (tbl_mark[h] == lhp_pkg::MARK_EMPTY) begin
        free_slot = (tomb >= 0) ? tomb : h;
        done = 1'b1;
      end else if (tbl_mark[h] == lhp_pkg::MARK_USED) begin
        if (tbl_key[h] == r.key) begin
          hit = h;
          done = 1'b1;
        end
      end else if (tomb < 0) begin
        tomb = h;
      end
      if (!done) h = (h + 1 == n) ? 0 : h + 1;
    end
    if (!done) free_slot = tomb;
    case (r.cmd)
      lhp_pkg::CMD_INSERT: begin
        if (hit >= 0) begin
          tbl_data[hit] = r.value;
        end else if (free_slot >= 0) begin
          tbl_key[free_slot] = r.key;
          tbl_data[free_slot] = r.value;
          tbl_mark[free_slot] = lhp_pkg::MARK_USED;
        end else begin
          res.status = lhp_pkg::ST_FULL;
        end
      end
      lhp_pkg::CMD_REMOVE: begin
        if (hit >= 0) tbl_mark[hit] = lhp_pkg::MARK_TOMB;
        else res.status = lhp_pkg::ST_NOT_FOUND;
      end
      default: begin
        if (hit >= 0) res.read_value = tbl_data[hit];
        else res.status = lhp_pkg::ST_NOT_FOUND;
      end
    endcase
    return res;
  endfunction

  function automatic logic [lhp_pkg::KEY_W-1:0] pick_key(logic [lhp_pkg::KEY_W-1:0] base,
                                                          int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return base + lhp_pkg::KEY_W'($urandom_range(0, span - 1));
    if (r < 95) return lhp_pkg::KEY_W'($urandom);
    if (r < 97) return 31'h0000_0000;
    return 31'h7FFF_FFFF;
  endfunction

  function automatic logic [lhp_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom;
    if (r < 89) return 32'h8000_0000;
    if (r < 93) return 32'h7FFF_FFFF;
    if (r < 96) return 32'hFFFF_FFFF;
    return 32'h0000_0000;
  endfunction

  task automatic send(lhp_pkg::cmd_t cmd, logic [lhp_pkg::KEY_W-1:0] key,
                      logic [lhp_pkg::DATA_W-1:0] value);
    request_q.push_back('{cmd: cmd, key: key, value: value});
    sent_count++;
  endtask

  task automatic wait_idle();
    while (resp_count != sent_count) @(posedge clk);
  endtask

  task automatic write_size(logic [lhp_pkg::CFG_W-1:0] size);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {lhp_pkg::REG_ACTIVE_SIZE, 2'b00};
    cfg_pwdata <= 32'(size);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tbl_size = size;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) response_q.push_back(lookup_and_update(in_flight));
      if (in_tvalid && !in_tready) begin
        // hold the request
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 16);
        in_tvalid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_flight = request_q.pop_front();
        in_tdata <= {7'd0, in_flight.value, in_flight.key, in_flight.cmd};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && resp_count >= 100) begin
      hold_done = 1'b1;
      hold_left = 299;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    map_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      resp_count++;
      if (response_q.size() == 0) begin
        $error("unexpected response: status %0d, read_value %h", out_tdata[1:0], out_tdata[33:2]);
        failed = 1'b1;
      end else begin
        want = response_q.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tdata[1:0]);
          failed = 1'b1;
        end
        if (out_tdata[33:2] !== want.read_value) begin
          $error("read_value: expected %h, actual %h", want.read_value, out_tdata[33:2]);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int p, j, n, r, ins_pct;
    logic [lhp_pkg::KEY_W-1:0] base;
    lhp_pkg::cmd_t cmd;
    for (j = 0; j < DEPTH; j++) tbl_mark[j] = lhp_pkg::MARK_EMPTY;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: collisions, wrap, tombstones, full table, unused command
    gaps_on = 1'b0;
    send(lhp_pkg::CMD_SEARCH, 31'd0, 32'h0);
    send(lhp_pkg::CMD_INSERT, 31'd0, 32'h8000_0000);
    send(lhp_pkg::CMD_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(lhp_pkg::CMD_INSERT, 31'd256, 32'hFFFF_FFFF);
    send(lhp_pkg::CMD_INSERT, 31'd255, 32'h1234_5678);
    send(lhp_pkg::CMD_SEARCH, 31'd255, 32'hFFFF_FFFF);
    send(lhp_pkg::CMD_REMOVE, 31'd0, 32'h0);
    send(lhp_pkg::CMD_SEARCH, 31'd256, 32'h0);
    send(lhp_pkg::CMD_REMOVE, 31'd0, 32'h0);
    send(lhp_pkg::CMD_INSERT, 31'd512, 32'h0);
    send(lhp_pkg::CMD_INSERT, 31'd256, 32'h0000_0001);
    send(lhp_pkg::CMD_SEARCH, 31'd256, 32'h0);
    send(lhp_pkg::CMD_SEARCH, 31'h7FFF_FFFF, 32'h0);
    send(lhp_pkg::CMD_NONE, 31'h2AAA_AAAA, 32'h5555_5555);
    send(lhp_pkg::CMD_SEARCH, 31'd512, 32'h0);
    wait_idle();
    write_size(9'd0);
    send(lhp_pkg::CMD_INSERT, 31'd7, 32'h0000_0007);
    send(lhp_pkg::CMD_SEARCH, 31'd7, 32'h0);
    send(lhp_pkg::CMD_REMOVE, 31'd512, 32'h0);
    send(lhp_pkg::CMD_SEARCH, 31'd512, 32'h0);
    send(lhp_pkg::CMD_INSERT, 31'd7, 32'hDEAD_BEEF);
    send(lhp_pkg::CMD_SEARCH, 31'd7, 32'h0);
    wait_idle();
    write_size(9'd256);
    send(lhp_pkg::CMD_SEARCH, 31'd256, 32'h0);
    send(lhp_pkg::CMD_SEARCH, 31'd512, 32'h0);
    wait_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_size(lhp_pkg::CFG_W'(phase_size[p]));
      n = (phase_size[p] < 1) ? 1 : (phase_size[p] > DEPTH) ? DEPTH : phase_size[p];
      gaps_on = (p == NUM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      base = ($urandom_range(0, 2) == 0) ? '0 : lhp_pkg::KEY_W'($urandom);
      ins_pct = (phase_size[p] == 257) ? 80 : 50;
      j = 0;
      if (phase_size[p] == 257) begin
        // fill every slot, then a few inserts that find the table full
        for (j = 0; j < n + 4; j++) begin
          send(lhp_pkg::CMD_INSERT, base + lhp_pkg::KEY_W'(j), pick_value());
        end
      end
      while (j < phase_len[p]) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) cmd = lhp_pkg::CMD_INSERT;
        else if (r < ins_pct + (100 - ins_pct) * 2 / 5) cmd = lhp_pkg::CMD_REMOVE;
        else if (r < 98) cmd = lhp_pkg::CMD_SEARCH;
        else cmd = lhp_pkg::CMD_NONE;
        send(cmd, pick_key(base, 2 * n + 4), pick_value());
        j++;
      end
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (!failed && response_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
